>>> design/tdpt_pkg.sv
// Shared types, widths and the control store of the trial-division prime tester.
// Holds the micro-op and branch-condition enums, the control word and the program.
// Depends on nothing; imported by trial_division_prime_test_core.
package tdpt_pkg;

  // Candidate width; the datapath follows it
  localparam int NumW = 32;
  // Step counter of the divider
  localparam int CntW = $clog2(NumW);
  // Program counter of the sequencer
  localparam int PcW = 4;

  // Datapath operation of one control word
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NONE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_BUMP,
    OP_EMIT_COMPOSITE,
    OP_EMIT_PRIME
  } op_e;

  // Branch condition of one control word; fall through to pc + 1 when false
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_LT_TWO,
    C_EQ_TWO,
    C_EVEN,
    C_DIV_BUSY,
    C_BEYOND_ROOT,
    C_REM_NONZERO
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } ctrl_word_t;

  // Program addresses
  localparam logic [PcW-1:0] PC_IDLE      = PcW'(0);
  localparam logic [PcW-1:0] PC_LT_TWO    = PcW'(1);
  localparam logic [PcW-1:0] PC_EQ_TWO    = PcW'(2);
  localparam logic [PcW-1:0] PC_EVEN      = PcW'(3);
  localparam logic [PcW-1:0] PC_DIV_INIT  = PcW'(4);
  localparam logic [PcW-1:0] PC_DIV_STEP  = PcW'(5);
  localparam logic [PcW-1:0] PC_BOUND     = PcW'(6);
  localparam logic [PcW-1:0] PC_REM       = PcW'(7);
  localparam logic [PcW-1:0] PC_COMPOSITE = PcW'(8);
  localparam logic [PcW-1:0] PC_PRIME     = PcW'(9);

  // Control store: one word per program step
  function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE:      w = '{op: OP_LOAD,           cond: C_NO_START,    target: PC_IDLE};
      PC_LT_TWO:    w = '{op: OP_NONE,           cond: C_LT_TWO,      target: PC_COMPOSITE};
      PC_EQ_TWO:    w = '{op: OP_NONE,           cond: C_EQ_TWO,      target: PC_PRIME};
      PC_EVEN:      w = '{op: OP_NONE,           cond: C_EVEN,        target: PC_COMPOSITE};
      PC_DIV_INIT:  w = '{op: OP_DIV_INIT,       cond: C_NEVER,       target: PC_IDLE};
      PC_DIV_STEP:  w = '{op: OP_DIV_STEP,       cond: C_DIV_BUSY,    target: PC_DIV_STEP};
      PC_BOUND:     w = '{op: OP_NONE,           cond: C_BEYOND_ROOT, target: PC_PRIME};
      PC_REM:       w = '{op: OP_BUMP,           cond: C_REM_NONZERO, target: PC_DIV_INIT};
      PC_COMPOSITE: w = '{op: OP_EMIT_COMPOSITE, cond: C_ALWAYS,      target: PC_IDLE};
      PC_PRIME:     w = '{op: OP_EMIT_PRIME,     cond: C_ALWAYS,      target: PC_IDLE};
      default:      w = '{op: OP_NONE,           cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/trial_division_prime_test_core.sv
// Trial-division primality tester: microcoded sequencer over a shift-subtract divider.
// Depends on tdpt_pkg (widths, control word type and control store).
//
// Usage:
//   Drive number_i and raise start; the word is taken at a rising edge where
//   start is high and busy is low. busy stays high while the test runs.
//   The answer appears on prime_o for exactly one cycle with done_o high;
//   the receiver has no way to stall it and must take it in that cycle.
// Sequencing:
//   Zero and one are reported composite and two prime after the screening steps;
//   other even numbers are reported composite. Odd numbers are screened, then each
//   odd trial divisor from 3 up goes through the divider load, one quotient bit
//   per cycle in the shared divider, then bound and remainder checks.
//   One word is in flight at a time; a new word may be started in the
//   cycle done_o is high.
// Reset:
//   rst_ni clears the program counter and the result strobe; the block comes
//   out of reset idle with busy low.
module trial_division_prime_test_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [tdpt_pkg::NumW-1:0] number_i,
  output logic                      done_o,
  output logic                      prime_o
);
  import tdpt_pkg::*;

  localparam logic [CntW-1:0] CntLast = CntW'(NumW - 1);

  logic [PcW-1:0]  pc_q, pc_d;
  ctrl_word_t      cw;
  logic            take;

  logic [NumW-1:0] n_q, d_q, quo_q, rem_q;
  logic [NumW-1:0] d_d, quo_d, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW:0]   shifted;
  logic            fits;

  logic            done_q, done_d;
  logic            prime_q, prime_d;

  // Fetch the control word of the current step
  assign cw   = ucode_rom(pc_q);
  assign busy = (pc_q != PC_IDLE);

  // Evaluate the branch condition and pick the next step
  always_comb begin
    case (cw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_START:    take = !start;
      C_LT_TWO:      take = (n_q[NumW-1:1] == '0);
      C_EQ_TWO:      take = (n_q == NumW'(2));
      C_EVEN:        take = !n_q[0];
      C_DIV_BUSY:    take = (cnt_q != CntLast);
      C_BEYOND_ROOT: take = (d_q > quo_q);
      C_REM_NONZERO: take = (rem_q != '0);
      default:       take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + PcW'(1);
  end

  // One shift-subtract step of the divider
  assign shifted = {rem_q, quo_q[NumW-1]};
  assign fits    = (shifted >= {1'b0, d_q});

  // Drive the datapath from the micro-op
  always_comb begin
    d_d     = d_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    case (cw.op)
      OP_LOAD: begin
        d_d = NumW'(3);
      end
      OP_DIV_INIT: begin
        quo_d = n_q;
        rem_d = '0;
        cnt_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = fits ? NumW'(shifted - {1'b0, d_q}) : shifted[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], fits};
        cnt_d = cnt_q + CntW'(1);
      end
      OP_BUMP: begin
        d_d = d_q + NumW'(2);
      end
      OP_EMIT_COMPOSITE: begin
        done_d  = 1'b1;
        prime_d = 1'b0;
      end
      OP_EMIT_PRIME: begin
        done_d  = 1'b1;
        prime_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_IDLE;
      done_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      done_q <= done_d;
    end
  end

  // Hold datapath registers; capture the candidate while idle
  always_ff @(posedge clk_i) begin
    if (cw.op == OP_LOAD) begin
      n_q <= number_i;
    end
    d_q     <= d_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  assign done_o  = done_q;
  assign prime_o = prime_q;

  // A result shows only once the sequencer is back at its idle step
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // An accepted word starts the program
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  // The strobe lasts a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // Only two or an odd number can be reported prime
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && prime_o) |-> (n_q[0] || (n_q == NumW'(2))))
    else $error("even number other than two reported prime");

endmodule

>>> verif/trial_division_prime_test_core_tb.sv
`timescale 1ns / 1ps
// Testbench for trial_division_prime_test_core: directed and random words, each answer checked
// against a typed-in answer or a trial-division predictor. Depends on tdpt_pkg and the core RTL.
module trial_division_prime_test_core_tb;
  import tdpt_pkg::*;

  typedef enum logic [1:0] {
    EXP_COMPOSITE,
    EXP_PRIME,
    EXP_PREDICT
  } answer_src_e;

  typedef struct packed {
    logic [NumW-1:0] number;
    answer_src_e     answer;
  } directed_row_t;

  typedef struct {
    logic [NumW-1:0] number;
    logic            prime;
  } verdict_t;

  localparam int NumDirected = 23;
  localparam int NumRandom   = 77;

  // Known answers typed in; everything else goes through the predictor
  localparam directed_row_t DirectedTbl [NumDirected] = '{
    '{32'd0,          EXP_COMPOSITE},
    '{32'd1,          EXP_COMPOSITE},
    '{32'd2,          EXP_PRIME},
    '{32'd3,          EXP_PRIME},
    '{32'd4,          EXP_COMPOSITE},
    '{32'd5,          EXP_PREDICT},
    '{32'd9,          EXP_PREDICT},
    '{32'd15,         EXP_PREDICT},
    '{32'd25,         EXP_PREDICT},
    '{32'd49,         EXP_PREDICT},
    '{32'd91,         EXP_PREDICT},
    '{32'd97,         EXP_PREDICT},
    '{32'd121,        EXP_PREDICT},
    '{32'd65535,      EXP_PREDICT},
    '{32'd65537,      EXP_PREDICT},
    '{32'd1042441,    EXP_PREDICT},
    '{32'd1048573,    EXP_PREDICT},
    '{32'h5555_5555,  EXP_PREDICT},
    '{32'hAAAA_AAAA,  EXP_PREDICT},
    '{32'h8000_0000,  EXP_COMPOSITE},
    '{32'h8000_0001,  EXP_PREDICT},
    '{32'hFFFF_FFFE,  EXP_COMPOSITE},
    '{32'hFFFF_FFFF,  EXP_COMPOSITE}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [NumW-1:0] number_i;
  logic            done_o;
  logic            prime_o;

  verdict_t verdict_q [$];
  int       mismatches = 0;
  int       burst_left = 0;

  trial_division_prime_test_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .number_i (number_i),
    .done_o   (done_o),
    .prime_o  (prime_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predict the answer: odd divisors from 3 while d <= n / d
  function automatic logic prime_by_division(input logic [NumW-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    if (v == 2) return 1'b1;
    if ((v & 1) == 0) return 1'b0;
    for (d = 3; d <= v / d; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Present a word and hold it until the core takes it
  task automatic send_word(input logic [NumW-1:0] n, input logic verdict);
    verdict_t entry;
    start    <= 1'b1;
    number_i <= n;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    entry.number = n;
    entry.prime  = verdict;
    verdict_q    = {verdict_q, entry};
  endtask

  // Drop start between bursts; zero-length gaps keep back-to-back stretches
  task automatic burst_gap();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // Hold off until every answer has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Check each strobed answer against the oldest expectation
  always @(posedge clk_i) begin : check_answer
    verdict_t want;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected answer prime=%0b, nothing outstanding",
                 $time, prime_o);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (prime_o !== want.prime) begin
          $display("%0t: number %0d prime expected %0b actual %0b",
                   $time, want.number, want.prime, prime_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [NumW-1:0] n;
    logic            verdict;
    int              kind;
    int              factor;
    rst_ni   = 1'b0;
    start    = 1'b0;
    number_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: extremes, the small special values, square bounds
    for (int i = 0; i < NumDirected; i++) begin
      burst_gap();
      n = DirectedTbl[i].number;
      case (DirectedTbl[i].answer)
        EXP_PRIME:     verdict = 1'b1;
        EXP_COMPOSITE: verdict = 1'b0;
        default:       verdict = prime_by_division(n);
      endcase
      send_word(n, verdict);
    end
    drain();

    // Random words: mostly small, some forced to carry a small odd factor, the rest wide even ones
    for (int i = 0; i < NumRandom; i++) begin
      burst_gap();
      if ($urandom_range(0, 19) == 0) drain();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(0, 1023);
      end else if (kind < 70) begin
        n = $urandom_range(0, 65535);
      end else if (kind < 88) begin
        factor = 2 * $urandom_range(1, 40) + 1;
        n = NumW'($urandom_range(1, 32'hFFFF_FFFF / factor) * factor);
      end else begin
        n = $urandom & ~32'd1;
      end
      send_word(n, prime_by_division(n));
    end
    drain();

    // Let any stray strobe show up before the verdict
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("trial_division_prime_test_core_tb: clean");
    end else begin
      $display("trial_division_prime_test_core_tb: errors");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin : watchdog
    #30_000_000;
    $display("trial_division_prime_test_core_tb: errors");
    $finish;
  end

endmodule
